### src/ptb_pkg.sv
// Shared types and constants for the per-tenant token bucket core.
package ptb_pkg;

    localparam int SLOT_IN_W  = 8;
    localparam int TICK_IN_W  = 32;
    localparam int RATE_W     = 32;
    localparam int HALF_W     = RATE_W / 2;
    localparam int BURST_W    = 16;
    localparam int TOKEN_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd655;
    localparam logic [BURST_W-1:0] BURST_RESET = 16'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] tenant_slot;
        logic [TICK_IN_W-1:0] now_tick;
    } req_t;

    typedef struct packed {
        logic               allowed;
        logic [TOKEN_W-1:0] tokens_left;
    } rsp_t;

endpackage

### src/ptb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ptb_refill.sv
// Multi-cycle refill unit: elapsed ticks times rate, saturated at the bucket cap.
module ptb_refill
    import ptb_pkg::*;
#(
    parameter int LVL_W     = 32,
    parameter int TICK_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TICK_BITS-1:0] now,
    input  logic [TICK_BITS-1:0] last,
    input  logic [LVL_W-1:0]     level_in,
    input  logic                 fresh,
    input  logic [RATE_W-1:0]    rate,
    input  logic [LVL_W-1:0]     cap,
    output logic                 done,
    output logic [LVL_W-1:0]     level_out
);

    localparam int EW = (TICK_BITS < LVL_W) ? TICK_BITS : LVL_W;
    localparam int PW = EW + HALF_W;
    localparam int SW = EW + RATE_W;

    typedef enum logic [1:0] {R_IDLE, R_LO, R_HI, R_SUM} phase_t;

    phase_t phase_reg, phase_next;
    logic   done_reg, done_next;

    logic [EW-1:0]    e_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic             fresh_reg;
    logic             ge_cap_reg;
    logic [LVL_W-1:0] room_reg;
    logic [PW-1:0]    prod_lo_reg;
    logic [PW-1:0]    prod_hi_reg;
    logic [LVL_W-1:0] result_reg;

    logic [TICK_BITS-1:0] elapsed;
    logic [EW-1:0]        e_clamp;
    logic [SW-1:0]        total;
    logic                 over;
    logic [LVL_W-1:0]     sum_level;

    // a gap beyond the level width always overflows the room when rate is nonzero
    assign elapsed   = now - last;
    assign e_clamp   = (elapsed > TICK_BITS'({EW{1'b1}})) ? {EW{1'b1}} : EW'(elapsed);
    assign total     = SW'(prod_lo_reg) + (SW'(prod_hi_reg) << HALF_W);
    assign over      = ge_cap_reg || (total > SW'(room_reg));
    assign sum_level = (fresh_reg || over) ? cap : lvl_reg + total[LVL_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    phase_next = R_LO;
                end
            end
            R_LO:
            begin
                phase_next = R_HI;
            end
            R_HI:
            begin
                phase_next = R_SUM;
            end
            R_SUM:
            begin
                phase_next = R_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                phase_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == R_IDLE && start)
        begin
            e_reg     <= e_clamp;
            lvl_reg   <= level_in;
            fresh_reg <= fresh;
        end
        if (phase_reg == R_LO)
        begin
            prod_lo_reg <= PW'(e_reg) * PW'(rate[HALF_W-1:0]);
            ge_cap_reg  <= lvl_reg >= cap;
            room_reg    <= cap - lvl_reg;
        end
        if (phase_reg == R_HI)
        begin
            prod_hi_reg <= PW'(e_reg) * PW'(rate[RATE_W-1:HALF_W]);
        end
        if (phase_reg == R_SUM)
        begin
            result_reg <= sum_level;
        end
    end

    assign done      = done_reg;
    assign level_out = result_reg;

endmodule

### src/per_tenant_token_bucket_core.sv
// Top level of the per-tenant token bucket rate limiter.
//
// Request channel (req_valid/req_ready, req): a tenant slot and the current
// tick. Response channel (rsp_valid/rsp_ready, rsp): allow bit and whole
// tokens left. Config port: cfg_we, cfg_index (0 rate, 1 burst), cfg_data.
// Buckets (valid mark, level, last tick) live in one RAM word per slot and
// are updated read-modify-write, one request at a time.
// Each request passes through the RAM read, the two-pass 16-bit
// partial-product multiply and the saturating add in ptb_refill.
// Reset: a clearing pass writes every slot invalid, with req_ready low;
// config writes are taken throughout.
// A stalled response sits in the output register; the next request is
// accepted and processed, and its write-back waits until the slot frees.
module per_tenant_token_bucket_core
    import ptb_pkg::*;
#(
    parameter int NUM_TENANTS = 256,
    parameter int FRAC_BITS   = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(NUM_TENANTS);
    localparam int LVL_W  = TOKEN_W + FRAC_BITS;
    localparam int WORD_W = 1 + LVL_W + TICK_BITS;
    localparam logic [LVL_W-1:0] ONE_TOKEN = LVL_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOAD, S_REFILL, S_WRITE} state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [BURST_W-1:0]  burst_reg, burst_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TICK_BITS-1:0] now_reg, now_next;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                 rd_valid;
    logic [LVL_W-1:0]     rd_level;
    logic [TICK_BITS-1:0] rd_tick;
    logic [LVL_W-1:0]     cap;
    logic                 refill_start;
    logic                 refill_done;
    logic [LVL_W-1:0]     refill_level;
    logic                 allow;
    logic [LVL_W-1:0]     final_level;

    // slot index modulo table depth, restoring subtract on 8 bits
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_IN_W-1:0] s);
        logic [SLOT_IN_W-1:0] r;
        r = s;
        for (int k = SLOT_IN_W - 1; k >= 0; k--)
        begin
            if (32'(r) >= 32'(NUM_TENANTS << k))
            begin
                r = r - SLOT_IN_W'(NUM_TENANTS << k);
            end
        end
        return SLOT_W'(r);
    endfunction

    ptb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_TENANTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_valid = ram_rdata[WORD_W-1];
    assign rd_level = ram_rdata[LVL_W+TICK_BITS-1:TICK_BITS];
    assign rd_tick  = ram_rdata[TICK_BITS-1:0];
    assign cap      = LVL_W'(burst_reg) << FRAC_BITS;

    assign refill_start = state_reg == S_LOAD;

    ptb_refill #(
        .LVL_W     (LVL_W),
        .TICK_BITS (TICK_BITS)
    ) u_refill (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (refill_start),
        .now       (now_reg),
        .last      (rd_tick),
        .level_in  (rd_level),
        .fresh     (!rd_valid),
        .rate      (rate_reg),
        .cap       (cap),
        .done      (refill_done),
        .level_out (refill_level)
    );

    assign allow       = refill_level >= ONE_TOKEN;
    assign final_level = allow ? refill_level - ONE_TOKEN : refill_level;

    assign req_ready = state_reg == S_IDLE;
    assign ram_re    = req_valid && req_ready;
    assign ram_raddr = slot_of(req.tenant_slot);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rate_next      = rate_reg;
        burst_next     = burst_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        slot_next      = slot_reg;
        now_next       = now_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = {1'b1, final_level, now_reg};

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RATE:  rate_next  = cfg_data;
                CFG_BURST: burst_next = cfg_data[BURST_W-1:0];
                default:   ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(NUM_TENANTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    slot_next  = slot_of(req.tenant_slot);
                    now_next   = TICK_BITS'(req.now_tick);
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_REFILL;
            end
            S_REFILL:
            begin
                if (refill_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ram_we               = 1'b1;
                    rsp_next.allowed     = allow;
                    rsp_next.tokens_left = final_level[LVL_W-1:FRAC_BITS];
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rate_reg      <= RATE_RESET;
            burst_reg     <= BURST_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rate_reg      <= rate_next;
            burst_reg     <= burst_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        slot_reg <= slot_next;
        now_reg  <= now_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_rsp_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(ram_we && state_reg == S_WRITE))
        else $error("response raised without a bucket write-back");

    a_tokens_capped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.tokens_left <= burst_reg)
        else $error("tokens left above burst limit");

    a_refill_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        refill_done |-> state_reg == S_REFILL)
        else $error("refill finished while control was not waiting for it");

endmodule

### test/per_tenant_token_bucket_checker.sv
`timescale 1ns / 100ps
// Checker for the token bucket core: models every bucket and compares each response word.
module per_tenant_token_bucket_checker
    import ptb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    rsp_owed,
    output int                    mismatch_count
);

    localparam int FRAC  = 16;
    localparam int SLOTS = 256;
    localparam logic [63:0] ONE_TOKEN = 64'd1 << FRAC;

    logic [RATE_W-1:0]    rate_q;
    logic [BURST_W-1:0]   burst_q;
    bit                   bucket_live [SLOTS];
    logic [31:0]          bucket_level [SLOTS];
    logic [TICK_IN_W-1:0] bucket_tick [SLOTS];
    rsp_t                 expected_rsp [$];
    rsp_t                 want_rsp;
    int                   rsp_seen = 0;
    int                   fails = 0;
    int                   owed_q = 0;

    assign rsp_owed       = owed_q;
    assign mismatch_count = fails;

    function automatic rsp_t charge_bucket(req_t w);
        int unsigned          s;
        logic [TICK_IN_W-1:0] diff;
        logic [63:0]          cap;
        logic [63:0]          level;
        logic [63:0]          prior;
        logic [63:0]          room;
        logic [63:0]          elapsed;
        logic [63:0]          rate64;
        rsp_t                 r;
        s      = int'(w.tenant_slot) % SLOTS;
        cap    = {48'b0, burst_q} << FRAC;
        rate64 = {32'b0, rate_q};
        if (!bucket_live[s])
        begin
            level          = cap;
            bucket_live[s] = 1'b1;
        end
        else
        begin
            diff    = w.now_tick - bucket_tick[s];
            elapsed = {32'b0, diff};
            prior   = {32'b0, bucket_level[s]};
            if (prior >= cap)
                level = cap;
            else
            begin
                room = cap - prior;
                if (elapsed != 0 && rate64 > room / elapsed)
                    level = cap;
                else
                    level = prior + elapsed * rate64;
            end
        end
        bucket_tick[s] = w.now_tick;
        r.allowed = 1'b0;
        if (level >= ONE_TOKEN)
        begin
            level     = level - ONE_TOKEN;
            r.allowed = 1'b1;
        end
        bucket_level[s] = level[31:0];
        r.tokens_left   = level[FRAC +: TOKEN_W];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] response word %0d: %s got %0h expected %0h",
                 $realtime, rsp_seen, what, got, want);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_q  = RATE_RESET;
            burst_q = BURST_RESET;
            foreach (bucket_live[i])
                bucket_live[i] = 1'b0;
            expected_rsp.delete();
            owed_q <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_RATE)
                    rate_q = cfg_data[RATE_W-1:0];
                else if (cfg_index == CFG_BURST)
                    burst_q = cfg_data[BURST_W-1:0];
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected word", 32'(rsp), 32'd0);
                else
                begin
                    want_rsp = expected_rsp.pop_front();
                    if (rsp.allowed !== want_rsp.allowed)
                        report_mismatch("allowed", 32'(rsp.allowed),
                                        32'(want_rsp.allowed));
                    if (rsp.tokens_left !== want_rsp.tokens_left)
                        report_mismatch("tokens_left", 32'(rsp.tokens_left),
                                        32'(want_rsp.tokens_left));
                end
                rsp_seen++;
            end
            if (req_valid && req_ready)
                expected_rsp.push_back(charge_bucket(req));
            owed_q <= expected_rsp.size();
        end
    end

endmodule

### test/per_tenant_token_bucket_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the token bucket core: clock, reset, request and config stimulus, verdict.
module per_tenant_token_bucket_core_test;
    import ptb_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 210;
    localparam int HOLD_CYCLES   = 400;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RATE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    rsp_owed;
    int                    mismatch_count;
    int                    cycle_count = 0;
    bit                    steady_send = 1'b0;

    per_tenant_token_bucket_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    per_tenant_token_bucket_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rsp_owed       (rsp_owed),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [SLOT_IN_W-1:0] slot, input logic [TICK_IN_W-1:0] tick);
        int gap;
        req       <= '{tenant_slot: slot, now_tick: tick};
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        gap = steady_send ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (rsp_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [RATE_W-1:0] rate, input logic [BURST_W-1:0] burst);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RATE;
        cfg_data  <= rate;
        @(posedge clk);
        cfg_index <= CFG_BURST;
        cfg_data  <= {16'($urandom), burst};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // response side: random stalls, two long hold-offs
    initial
    begin
        int rx_cycles;
        int holdoffs;
        int stall;
        int run;
        rx_cycles = 0;
        holdoffs  = 0;
        @(posedge clk);
        forever
        begin
            if (holdoffs < 2 && rx_cycles >= 1500 + holdoffs * 7500)
            begin
                stall = HOLD_CYCLES;
                holdoffs++;
            end
            else
                stall = idle_gap();
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                rx_cycles += stall;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clk);
            rx_cycles += run;
        end
    end

    initial
    begin
        int                   phase;
        int                   n;
        int                   pick;
        logic [TICK_IN_W-1:0] tick_now;
        logic [RATE_W-1:0]    rate;
        logic [BURST_W-1:0]   burst;
        logic [SLOT_IN_W-1:0] slot;
        logic [SLOT_IN_W-1:0] slot_pool [4];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: first fill, drain, sub-token refill
        send_word(8'd0, 32'd0);
        send_word(8'd0, 32'd0);
        send_word(8'd255, 32'hFFFF_FFFF);
        send_word(8'd0, 32'd100);

        // zero rate, burst of one: clamp to burst, denials
        set_config(32'd0, 16'd1);
        send_word(8'd0, 32'd200);
        send_word(8'd0, 32'd300);
        send_word(8'd0, 32'd400);
        send_word(8'd3, 32'd400);

        // max rate and burst: saturating refill, zero elapsed, tick going backwards
        set_config(32'hFFFF_FFFF, 16'hFFFF);
        send_word(8'd0, 32'd401);
        send_word(8'd0, 32'd401);
        send_word(8'd0, 32'd400);
        send_word(8'd128, 32'h8000_0000);

        // zero burst: level above burst clamps down, new slot denied
        set_config(32'h0001_0000, 16'd0);
        send_word(8'd0, 32'd402);
        send_word(8'd9, 32'd402);

        // one token per tick, small burst
        set_config(32'h0001_0000, 16'd3);
        send_word(8'd0, 32'd403);
        send_word(8'd0, 32'd403);
        send_word(8'd0, 32'd405);
        send_word(8'd0, 32'h7FFF_FFFF);
        send_word(8'd1, 32'h0000_8000);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 7))
                0: rate = 32'd0;
                1: rate = 32'hFFFF_FFFF;
                2: rate = 32'd655;
                3: rate = 32'h0001_0000;
                4: rate = $urandom_range(1, 4096);
                5: rate = $urandom_range(1, 1 << 18);
                6: rate = $urandom;
                default: rate = $urandom_range(1 << 12, 1 << 15);
            endcase
            case ($urandom_range(0, 5))
                0: burst = 16'd1;
                1: burst = BURST_W'($urandom_range(1, 4));
                2: burst = BURST_W'($urandom_range(2, 16));
                3: burst = 16'hFFFF;
                4: burst = BURST_W'($urandom_range(1, 65535));
                default: burst = 16'd0;
            endcase
            set_config(rate, burst);
            steady_send = ($urandom_range(0, 3) == 0);
            foreach (slot_pool[i])
                slot_pool[i] = SLOT_IN_W'($urandom);
            tick_now = $urandom;
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    tick_now += $urandom_range(0, 3);
                else if (pick < 80)
                    tick_now += $urandom_range(0, 300);
                else if (pick < 93)
                    tick_now += $urandom_range(0, 40000);
                else
                    tick_now = $urandom;
                if ($urandom_range(0, 3) != 0)
                    slot = slot_pool[$urandom_range(0, 3)];
                else
                    slot = SLOT_IN_W'($urandom);
                send_word(slot, tick_now);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && rsp_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
